@@ rtl/sfr_pkg.sv @@
// Shared types, codes and the control-word program of the stream find-and-replace block.
// Used by sfr_seq and stream_find_and_replace; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int CODE_W = 21;
    localparam int STEP_W = 3;

    // input item kinds
    localparam logic [1:0] FUNC_TEXT = 2'd0;
    localparam logic [1:0] FUNC_PAT  = 2'd1;
    localparam logic [1:0] FUNC_REP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_IGNORE_CASE = 2'd0;
    localparam logic [1:0] REG_PAT_LEN     = 2'd1;
    localparam logic [1:0] REG_REP_LEN     = 2'd2;

    // program steps
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TEST  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_REP   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_FLUSH = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;

    // datapath actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_EMIT_WIN = 2'd1;
    localparam logic [1:0] ACT_EMIT_REP = 2'd2;
    localparam logic [1:0] ACT_FINISH   = 2'd3;

    // jump conditions
    localparam logic [2:0] COND_NEVER      = 3'd0;
    localparam logic [2:0] COND_PASS       = 3'd1;
    localparam logic [2:0] COND_TEXT       = 3'd2;
    localparam logic [2:0] COND_MATCH      = 3'd3;
    localparam logic [2:0] COND_PREFIX     = 3'd4;
    localparam logic [2:0] COND_REP_DONE   = 3'd5;
    localparam logic [2:0] COND_FLUSH_DONE = 3'd6;

    typedef struct packed {
        logic              accept;
        logic [1:0]        act;
        logic [2:0]        cond_a;
        logic [STEP_W-1:0] tgt_a;
        logic              clr_a;
        logic [2:0]        cond_b;
        logic [STEP_W-1:0] tgt_b;
        logic [STEP_W-1:0] nxt;
    } ucode_t;

    typedef struct packed {
        logic text_acc;
        logic pass_acc;
        logic full_match;
        logic prefix;
        logic rep_done;
        logic flush_done;
    } flags_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        ucode_t            ctl;
        logic              jump_a;
        logic              jump_b;
        logic              act_en;
    } seq_stat_t;

    // The program: two prioritised jumps, else the action runs and the default step follows.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            case (step)
                STEP_IDLE:  w = '{accept: 1'b1, act: ACT_NONE,
                                  cond_a: COND_PASS, tgt_a: STEP_DONE, clr_a: 1'b1,
                                  cond_b: COND_TEXT, tgt_b: STEP_TEST, nxt: STEP_IDLE};
                STEP_TEST:  w = '{accept: 1'b0, act: ACT_EMIT_WIN,
                                  cond_a: COND_MATCH, tgt_a: STEP_REP, clr_a: 1'b1,
                                  cond_b: COND_PREFIX, tgt_b: STEP_FLUSH, nxt: STEP_TEST};
                STEP_REP:   w = '{accept: 1'b0, act: ACT_EMIT_REP,
                                  cond_a: COND_REP_DONE, tgt_a: STEP_FLUSH, clr_a: 1'b0,
                                  cond_b: COND_NEVER, tgt_b: STEP_IDLE, nxt: STEP_REP};
                STEP_FLUSH: w = '{accept: 1'b0, act: ACT_EMIT_WIN,
                                  cond_a: COND_FLUSH_DONE, tgt_a: STEP_DONE, clr_a: 1'b0,
                                  cond_b: COND_NEVER, tgt_b: STEP_IDLE, nxt: STEP_FLUSH};
                STEP_DONE:  w = '{accept: 1'b0, act: ACT_FINISH,
                                  cond_a: COND_NEVER, tgt_a: STEP_IDLE, clr_a: 1'b0,
                                  cond_b: COND_NEVER, tgt_b: STEP_IDLE, nxt: STEP_IDLE};
                default:    w = '{accept: 1'b0, act: ACT_NONE,
                                  cond_a: COND_NEVER, tgt_a: STEP_IDLE, clr_a: 1'b0,
                                  cond_b: COND_NEVER, tgt_b: STEP_IDLE, nxt: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

    // Fold ASCII a-z to upper case when case-blind.
    function automatic logic [31:0] fold_upper(input logic [31:0] c, input logic blind);
        logic [31:0] r;
        begin
            r = c;
            if (blind && (c inside {[32'h61:32'h7A]}))
                r = c - 32'h20;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/sfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sfr_seq.sv @@
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on sfr_pkg for the control word, flag and status types.
`timescale 1ns / 1ps
`default_nettype none

module sfr_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfr_pkg::flags_t    flags,
    input  wire logic               go,
    output sfr_pkg::seq_stat_t      stat
);

    logic [sfr_pkg::STEP_W-1:0] step_reg;
    logic [sfr_pkg::STEP_W-1:0] step_next;
    sfr_pkg::ucode_t            ctl;
    logic                       jump_a;
    logic                       jump_b;

    function automatic logic cond_true(input logic [2:0] c, input sfr_pkg::flags_t f);
        logic r;
        begin
            case (c)
                sfr_pkg::COND_NEVER:      r = 1'b0;
                sfr_pkg::COND_PASS:       r = f.pass_acc;
                sfr_pkg::COND_TEXT:       r = f.text_acc;
                sfr_pkg::COND_MATCH:      r = f.full_match;
                sfr_pkg::COND_PREFIX:     r = f.prefix;
                sfr_pkg::COND_REP_DONE:   r = f.rep_done;
                sfr_pkg::COND_FLUSH_DONE: r = f.flush_done;
                default:                  r = 1'b0;
            endcase
            return r;
        end
    endfunction

    always_comb
    begin
        ctl    = sfr_pkg::ucode_rom(step_reg);
        jump_a = cond_true(ctl.cond_a, flags);
        jump_b = !jump_a && cond_true(ctl.cond_b, flags);
        if (jump_a)
            step_next = ctl.tgt_a;
        else if (jump_b)
            step_next = ctl.tgt_b;
        else if (go)
            step_next = ctl.nxt;
        else
            step_next = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= sfr_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

    assign stat = '{step: step_reg, ctl: ctl, jump_a: jump_a, jump_b: jump_b,
                    act_en: !jump_a && !jump_b};

endmodule

`default_nettype wire

@@ rtl/stream_find_and_replace.sv @@
// Top level of the stream find-and-replace block: config registers, window, pattern
// registers, output staging. Depends on sfr_pkg, sfr_seq and sfr_ram.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  cfg     | psel/penable/pwrite, pready  | paddr, pwdata, prdata (regs at 0x0/0x4/0x8)
//  in      | in_valid / in_ready          | func, slot, char_code, text_end
//  out     | out_valid / out_ready        | out_code, has_char, run_last, output_end
//
// Load items are taken while idle. A text item passes straight through with pattern_length
// 0; otherwise held characters are written out, plus the replacement characters on a match,
// as the microprogram steps through test, replace, flush and done. The replacement store is
// read one character a cycle through the RAM's registered port while emission is not stalled.
// Reset clears the step counter, window count, config registers and valid flags.
// A full output register stalls emission; the last emitted character is held back in a
// pending register so that run_last and output_end can be set on it.
`timescale 1ns / 1ps
`default_nettype none

module stream_find_and_replace #(
    parameter int PATTERN_MAX     = 16,
    parameter int REPLACEMENT_MAX = 16,
    parameter int CHAR_BITS       = 21
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  slot,
    input  wire logic [20:0] char_code,
    input  wire logic        text_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [20:0]      out_code,
    output logic             has_char,
    output logic             run_last,
    output logic             output_end
);

    localparam int WC_W   = $clog2(PATTERN_MAX + 1);
    localparam int RI_W   = $clog2(REPLACEMENT_MAX + 1);
    localparam int RAM_AW = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;
    localparam int CW     = (CHAR_BITS < sfr_pkg::CODE_W) ? CHAR_BITS : sfr_pkg::CODE_W;

    // configuration
    logic        ignore_case_reg;
    logic [4:0]  pattern_length_reg;
    logic [4:0]  replacement_length_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // sequencer
    sfr_pkg::flags_t    flags;
    sfr_pkg::seq_stat_t seq_stat;
    logic               act_go;
    logic               emit_fire;
    logic               finish_fire;

    // datapath
    logic [CW-1:0]   code_in;
    logic            accept;
    logic            text_acc;
    logic            pass_acc;
    logic            append;
    logic [WC_W-1:0] pat_len;
    logic [RI_W-1:0] rep_len;
    logic [WC_W-1:0] wc_reg;
    logic [WC_W-1:0] wc_next;
    logic [WC_W-1:0] wc_eff;
    logic [CW-1:0]   win_reg [PATTERN_MAX];
    logic [CW-1:0]   win_next [PATTERN_MAX];
    logic [CW-1:0]   pat_reg [PATTERN_MAX];
    logic [CW-1:0]   pat_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] ok;
    logic            pre;
    logic            fin_reg;
    logic [RI_W-1:0] rep_idx_reg;
    logic [RI_W-1:0] rep_idx_next;
    logic            rep_we;
    logic [CW-1:0]   rep_rdata;
    logic [CW-1:0]   emit_code;
    logic            out_free;

    logic            pend_valid_reg;
    logic            pend_valid_next;
    logic [CW-1:0]   pend_code_reg;
    logic [CW-1:0]   pend_code_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [CW-1:0]   out_code_reg;
    logic [CW-1:0]   out_code_next;
    logic            has_char_reg;
    logic            has_char_next;
    logic            run_last_reg;
    logic            run_last_next;
    logic            output_end_reg;
    logic            output_end_next;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            sfr_pkg::REG_IGNORE_CASE: prdata = 32'(ignore_case_reg);
            sfr_pkg::REG_PAT_LEN:     prdata = 32'(pattern_length_reg);
            sfr_pkg::REG_REP_LEN:     prdata = 32'(replacement_length_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        if (32'(pattern_length_reg) > PATTERN_MAX)
            pat_len = WC_W'(PATTERN_MAX);
        else
            pat_len = WC_W'(pattern_length_reg);
        if (32'(replacement_length_reg) > REPLACEMENT_MAX)
            rep_len = RI_W'(REPLACEMENT_MAX);
        else
            rep_len = RI_W'(replacement_length_reg);
    end

    // ---------------- sequencer ----------------
    sfr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .go    (act_go),
        .stat  (seq_stat)
    );

    assign in_ready = seq_stat.ctl.accept;
    assign accept   = in_valid && in_ready;
    assign code_in  = CW'(char_code);
    assign text_acc = accept && (func == sfr_pkg::FUNC_TEXT);
    assign pass_acc = text_acc && (pat_len == '0);
    assign append   = text_acc && (pat_len != '0);
    assign out_free = !out_valid_reg || out_ready;

    // prefix test of the whole window against the pattern, one compare per position
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            ok[i] = (wc_reg <= WC_W'(i)) ||
                    (sfr_pkg::fold_upper(32'(win_reg[i]), ignore_case_reg) ==
                     sfr_pkg::fold_upper(32'(pat_reg[i]), ignore_case_reg));
        end
        pre = &ok;
    end

    assign flags = '{text_acc:   text_acc,
                     pass_acc:   pass_acc,
                     full_match: pre && (wc_reg == pat_len),
                     prefix:     pre,
                     rep_done:   rep_idx_reg == rep_len,
                     flush_done: !fin_reg || (wc_reg == '0)};

    always_comb
    begin
        case (seq_stat.ctl.act)
            sfr_pkg::ACT_NONE:     act_go = 1'b1;
            sfr_pkg::ACT_EMIT_WIN: act_go = !pend_valid_reg || out_free;
            sfr_pkg::ACT_EMIT_REP: act_go = !pend_valid_reg || out_free;
            sfr_pkg::ACT_FINISH:   act_go = !(pend_valid_reg || fin_reg) || out_free;
            default:               act_go = 1'b1;
        endcase
    end

    assign emit_fire = seq_stat.act_en && act_go &&
                       ((seq_stat.ctl.act == sfr_pkg::ACT_EMIT_WIN) ||
                        (seq_stat.ctl.act == sfr_pkg::ACT_EMIT_REP));
    assign finish_fire = seq_stat.act_en && act_go && (seq_stat.ctl.act == sfr_pkg::ACT_FINISH);
    assign emit_code   = (seq_stat.ctl.act == sfr_pkg::ACT_EMIT_REP) ? rep_rdata : win_reg[0];

    // ---------------- replacement store ----------------
    assign rep_we = accept && (func == sfr_pkg::FUNC_REP) && (32'(slot) < REPLACEMENT_MAX);

    // read one ahead: the address is the next index, so data lines up with rep_idx_reg
    always_comb
    begin
        if (seq_stat.step != sfr_pkg::STEP_REP)
            rep_idx_next = '0;
        else if (emit_fire)
            rep_idx_next = rep_idx_reg + RI_W'(1);
        else
            rep_idx_next = rep_idx_reg;
    end

    sfr_ram #(
        .WIDTH (CW),
        .DEPTH (REPLACEMENT_MAX),
        .AW    (RAM_AW)
    ) u_rep_ram (
        .clk   (clk),
        .we    (rep_we),
        .waddr (RAM_AW'(slot)),
        .wdata (code_in),
        .raddr (RAM_AW'(rep_idx_next)),
        .rdata (rep_rdata)
    );

    // ---------------- window and pattern ----------------
    assign wc_eff = (wc_reg >= pat_len) ? '0 : wc_reg;

    always_comb
    begin
        win_next = win_reg;
        pat_next = pat_reg;
        wc_next  = wc_reg;
        if (accept && (func == sfr_pkg::FUNC_PAT))
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (32'(slot) == 32'(i))
                    pat_next[i] = code_in;
            end
        end
        if (append)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (wc_eff == WC_W'(i))
                    win_next[i] = code_in;
            end
            wc_next = wc_eff + WC_W'(1);
        end
        if (emit_fire && (seq_stat.ctl.act == sfr_pkg::ACT_EMIT_WIN))
        begin
            // drop the head, advance the rest
            for (int i = 0; i < PATTERN_MAX - 1; i++)
                win_next[i] = win_reg[i + 1];
            wc_next = wc_reg - WC_W'(1);
        end
        if (seq_stat.jump_a && seq_stat.ctl.clr_a)
            wc_next = '0;
        if (cfg_wr && (cfg_idx == sfr_pkg::REG_PAT_LEN))
            wc_next = '0;
    end

    // ---------------- held-back character and output register ----------------
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_code_next   = out_code_reg;
        has_char_next   = has_char_reg;
        run_last_next   = run_last_reg;
        output_end_next = output_end_reg;
        if (pass_acc)
        begin
            pend_valid_next = 1'b1;
            pend_code_next  = code_in;
        end
        if (emit_fire)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = pend_code_reg;
                has_char_next   = 1'b1;
                run_last_next   = 1'b0;
                output_end_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_code_next  = emit_code;
        end
        if (finish_fire)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = pend_code_reg;
                has_char_next   = 1'b1;
                run_last_next   = 1'b1;
                output_end_next = fin_reg;
            end
            else if (fin_reg)
            begin
                // end of text with nothing to show: bare end marker
                out_valid_next  = 1'b1;
                out_code_next   = '0;
                has_char_next   = 1'b0;
                run_last_next   = 1'b1;
                output_end_next = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg        <= 1'b0;
            pattern_length_reg     <= '0;
            replacement_length_reg <= '0;
            wc_reg                 <= '0;
            fin_reg                <= 1'b0;
            rep_idx_reg            <= '0;
            pend_valid_reg         <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    sfr_pkg::REG_IGNORE_CASE: ignore_case_reg        <= pwdata[0];
                    sfr_pkg::REG_PAT_LEN:     pattern_length_reg     <= pwdata[4:0];
                    sfr_pkg::REG_REP_LEN:     replacement_length_reg <= pwdata[4:0];
                    default:                  ;
                endcase
            end
            if (text_acc)
                fin_reg <= text_end;
            wc_reg         <= wc_next;
            rep_idx_reg    <= rep_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg        <= win_next;
        pat_reg        <= pat_next;
        pend_code_reg  <= pend_code_next;
        out_code_reg   <= out_code_next;
        has_char_reg   <= has_char_next;
        run_last_reg   <= run_last_next;
        output_end_reg <= output_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_code   = sfr_pkg::CODE_W'(out_code_reg);
    assign has_char   = has_char_reg;
    assign run_last   = run_last_reg;
    assign output_end = output_end_reg;

    // ---------------- assertions ----------------
    a_done_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_stat.step == sfr_pkg::STEP_DONE && fin_reg) |-> (wc_reg == '0))
        else $error("window not empty when the text is closed");

    a_idle_partial_window: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_stat.step == sfr_pkg::STEP_IDLE) |-> (wc_reg == '0 || wc_reg < pat_len))
        else $error("idle window holds a full pattern length");

    a_rep_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_stat.step == sfr_pkg::STEP_REP) |-> (rep_idx_reg <= rep_len))
        else $error("replacement index past its length");

    a_pend_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_stat.act_en && !act_go && pend_valid_reg) |=> $stable(pend_code_reg))
        else $error("held-back item changed during an output stall");

endmodule

`default_nettype wire
